FILE: design/pra_pkg.sv
// Package for the page run allocator: codes, field widths and the
// controller/datapath command and status structs. No dependencies.
package pra_pkg;

    localparam int CMD_W    = 2;
    localparam int AMT_W    = 27;
    localparam int ACR_W    = 3;
    localparam int VA_W     = 26;
    localparam int STAT_W   = 3;
    localparam int AVAIL_W  = 14;
    localparam int ENTRY_W  = 21;
    localparam int PAGE_W   = 16;
    localparam int RSV_W    = 13;
    localparam int LAST_BIT = 20;
    localparam int MID_BIT  = 19;
    localparam logic [ENTRY_W-1:0] KEEP_MASK = 21'h07FFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_READ    = 2'd2,
        CMD_REBUILD = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        RS_OK       = 3'd0,
        RS_BAD      = 3'd1,
        RS_SHORT    = 3'd2,
        RS_NORUN    = 3'd3,
        RS_NOTALLOC = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FILL_RD,
        S_FILL_WR,
        S_FREE_RD,
        S_FREE_CHK,
        S_READ_RD,
        S_READ_CAP,
        S_SWEEP,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic    in_ready;
        logic    clr_step;
        logic    link_step;
        logic    rebuild_init;
        logic    scan_chk;
        logic    fill_wr;
        logic    free_wr;
        logic    read_cap;
        logic    set_status;
        status_t status;
        logic    load_out;
    } ctl_t;

    typedef struct packed {
        cmd_t cmd;
        logic accepted;
        logic bad_req;
        logic short_pages;
        logic too_long;
        logic idx_oob;
        logic scan_hit;
        logic scan_end;
        logic fill_last;
        logic marked;
        logic last_mark;
        logic first;
        logic ptr_end;
        logic sweep_last_link;
        logic sweep_last_all;
        logic out_busy;
    } sts_t;

endpackage

FILE: design/pra_if.sv
// Handshake interfaces for request, response and configuration channels.
// Depends on pra_pkg for field widths.
interface pra_req_if;
    import pra_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [AMT_W-1:0] byte_amount;
    logic [ACR_W-1:0] access_right;
    logic [VA_W-1:0]  virtual_address;
    modport source (output valid, cmd, byte_amount, access_right, virtual_address,
                    input ready);
    modport sink (input valid, cmd, byte_amount, access_right, virtual_address,
                  output ready);
endinterface

interface pra_rsp_if;
    import pra_pkg::*;
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [VA_W-1:0]    base_address;
    logic [AVAIL_W-1:0] pages_available;
    logic [ENTRY_W-1:0] entry_word;
    modport source (output valid, status, base_address, pages_available, entry_word,
                    input ready);
    modport sink (input valid, status, base_address, pages_available, entry_word,
                  output ready);
endinterface

interface pra_cfg_if;
    import pra_pkg::*;
    logic             valid;
    logic             ready;
    logic [RSV_W-1:0] reserved_pages;
    modport source (output valid, reserved_pages, input ready);
    modport sink (input valid, reserved_pages, output ready);
endinterface

FILE: design/pra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/pra_ctrl.sv
// Controller state machine of the page run allocator.
// Depends on pra_pkg; drives ctl_t commands from sts_t status.
module pra_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  pra_pkg::sts_t sts,
    output pra_pkg::ctl_t ctl
);
    import pra_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (sts.sweep_last_all) state_next = S_IDLE;
            S_IDLE:     if (sts.accepted) state_next = S_DECODE;
            S_DECODE:
            begin
                unique case (sts.cmd)
                    CMD_ALLOC:
                        if (sts.bad_req || sts.short_pages || sts.too_long)
                            state_next = S_RESULT;
                        else
                            state_next = S_SCAN_RD;
                    CMD_FREE:    state_next = sts.idx_oob ? S_RESULT : S_FREE_RD;
                    CMD_READ:    state_next = sts.idx_oob ? S_RESULT : S_READ_RD;
                    CMD_REBUILD: state_next = S_SWEEP;
                    default:     state_next = S_RESULT;
                endcase
            end
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if (sts.scan_hit)
                    state_next = S_FILL_RD;
                else if (sts.scan_end)
                    state_next = S_RESULT;
                else
                    state_next = S_SCAN_RD;
            end
            S_FILL_RD:  state_next = S_FILL_WR;
            S_FILL_WR:  state_next = sts.fill_last ? S_RESULT : S_FILL_RD;
            S_FREE_RD:  state_next = S_FREE_CHK;
            S_FREE_CHK:
            begin
                if (!sts.marked || sts.last_mark || sts.ptr_end)
                    state_next = S_RESULT;
                else
                    state_next = S_FREE_RD;
            end
            S_READ_RD:  state_next = S_READ_CAP;
            S_READ_CAP: state_next = S_RESULT;
            S_SWEEP:    if (sts.sweep_last_link) state_next = S_RESULT;
            S_RESULT:   if (!sts.out_busy) state_next = S_IDLE;
            default:    state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ctl.status = RS_OK;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step  = 1'b1;
                ctl.link_step = 1'b1;
            end
            S_IDLE:
            begin
                ctl.in_ready = 1'b1;
            end
            S_DECODE:
            begin
                unique case (sts.cmd)
                    CMD_ALLOC:
                    begin
                        ctl.set_status = sts.bad_req || sts.short_pages || sts.too_long;
                        if (sts.bad_req)
                            ctl.status = RS_BAD;
                        else if (sts.short_pages)
                            ctl.status = RS_SHORT;
                        else
                            ctl.status = RS_NORUN;
                    end
                    CMD_FREE, CMD_READ:
                    begin
                        ctl.set_status = sts.idx_oob;
                        ctl.status     = RS_BAD;
                    end
                    CMD_REBUILD: ctl.rebuild_init = 1'b1;
                    default: ctl.set_status = 1'b0;
                endcase
            end
            S_SCAN_CHK:
            begin
                ctl.scan_chk   = 1'b1;
                ctl.set_status = !sts.scan_hit && sts.scan_end;
                ctl.status     = RS_NORUN;
            end
            S_FILL_WR:  ctl.fill_wr = 1'b1;
            S_FREE_CHK:
            begin
                ctl.free_wr    = sts.marked;
                ctl.set_status = !sts.marked && sts.first;
                ctl.status     = RS_NOTALLOC;
            end
            S_READ_CAP: ctl.read_cap = 1'b1;
            S_SWEEP:    ctl.link_step = 1'b1;
            S_RESULT:   ctl.load_out = !sts.out_busy;
            default:    ctl.in_ready = 1'b0;
        endcase
    end
endmodule

FILE: design/pra_dp.sv
// Datapath of the page run allocator: link memory, page table, free list
// head and count, scan/walk pointers and the result register. Uses pra_pkg, pra_ram.
module pra_dp #(
    parameter int PHYS_PAGES    = 8192,
    parameter int TABLE_ENTRIES = 1024,
    parameter int PAGE_SHIFT    = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    pra_req_if.sink       req,
    pra_rsp_if.source     rsp,
    pra_cfg_if.sink       cfg,
    input  pra_pkg::ctl_t ctl,
    output pra_pkg::sts_t sts
);
    import pra_pkg::*;

    localparam int LINK_W  = $clog2(PHYS_PAGES);
    localparam int CNT_W   = $clog2(PHYS_PAGES + 1);
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int PTR_W   = IDX_W + 1;
    localparam int NP_W    = AMT_W + 1 - PAGE_SHIFT;
    localparam int VIDX_W  = VA_W - PAGE_SHIFT;
    localparam int SWEEP_N = (PHYS_PAGES > TABLE_ENTRIES) ? PHYS_PAGES : TABLE_ENTRIES;
    localparam int SW_W    = $clog2(SWEEP_N);
    localparam int RSV_RST = 16;

    cmd_t               cmd_reg;
    logic [NP_W-1:0]    np_reg;
    logic [ACR_W-1:0]   acr_reg;
    logic [VIDX_W-1:0]  vidx_reg;
    logic [RSV_W-1:0]   reserved_reg;
    logic [LINK_W-1:0]  head_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   run_reg;
    logic [PTR_W-1:0]   k_reg;
    logic [SW_W-1:0]    sweep_reg;
    status_t            status_reg;
    logic [VA_W-1:0]    base_reg;
    logic [ENTRY_W-1:0] word_reg;
    logic               out_valid_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [VA_W-1:0]    out_base_reg;
    logic [AVAIL_W-1:0] out_avail_reg;
    logic [ENTRY_W-1:0] out_word_reg;

    logic [AMT_W:0]     amt_sum;
    logic [NP_W-1:0]    np_in;
    logic               accepted;
    logic [ENTRY_W-1:0] tbl_rdata;
    logic [ENTRY_W-1:0] tbl_wdata;
    logic [IDX_W-1:0]   tbl_waddr;
    logic               tbl_we;
    logic [LINK_W-1:0]  link_rdata;
    logic [LINK_W-1:0]  link_wdata;
    logic [LINK_W-1:0]  link_waddr;
    logic               link_we;
    logic [PAGE_W-1:0]  ent_page;
    logic               push_ok;
    logic               marked;
    logic [PTR_W-1:0]   run_start;
    logic               fill_last;

    assign accepted = req.valid && ctl.in_ready;
    assign req.ready = ctl.in_ready;
    assign cfg.ready = 1'b1;

    assign amt_sum = {1'b0, req.byte_amount} + (AMT_W + 1)'((1 << PAGE_SHIFT) - 1);
    assign np_in   = amt_sum[AMT_W:PAGE_SHIFT];

    assign marked    = tbl_rdata[LAST_BIT] || tbl_rdata[MID_BIT];
    assign ent_page  = tbl_rdata[PAGE_W-1:0];
    assign push_ok   = (32'(ent_page) >= 32'(reserved_reg)) && (32'(ent_page) < PHYS_PAGES)
                       && (32'(count_reg) < PHYS_PAGES);
    assign run_start = PTR_W'(ptr_reg - PTR_W'(np_reg) + PTR_W'(1));
    assign fill_last = (32'(k_reg) + 1) == 32'(np_reg);

    always_comb
    begin
        sts                 = '0;
        sts.cmd             = cmd_reg;
        sts.accepted        = accepted;
        sts.bad_req         = (acr_reg == '0) || (np_reg == '0);
        sts.short_pages     = 32'(np_reg) > 32'(count_reg);
        sts.too_long        = 32'(np_reg) > TABLE_ENTRIES;
        sts.idx_oob         = 32'(vidx_reg) >= TABLE_ENTRIES;
        sts.scan_hit        = !marked && ((32'(run_reg) + 1) == 32'(np_reg));
        sts.scan_end        = 32'(ptr_reg) == (TABLE_ENTRIES - 1);
        sts.fill_last       = fill_last;
        sts.marked          = marked;
        sts.last_mark       = tbl_rdata[LAST_BIT];
        sts.first           = k_reg == '0;
        sts.ptr_end         = 32'(ptr_reg) == (TABLE_ENTRIES - 1);
        sts.sweep_last_link = 32'(sweep_reg) == (PHYS_PAGES - 1);
        sts.sweep_last_all  = 32'(sweep_reg) == (SWEEP_N - 1);
        sts.out_busy        = out_valid_reg && !rsp.ready;
    end

    // Table write port: clearing sweep, run fill, or mark clear on free.
    always_comb
    begin
        tbl_we    = 1'b0;
        tbl_waddr = IDX_W'(ptr_reg);
        tbl_wdata = '0;
        if (ctl.clr_step)
        begin
            tbl_we    = 32'(sweep_reg) < TABLE_ENTRIES;
            tbl_waddr = IDX_W'(sweep_reg);
        end
        else if (ctl.fill_wr)
        begin
            tbl_we    = 1'b1;
            tbl_wdata = {fill_last, !fill_last, acr_reg, PAGE_W'(head_reg)};
        end
        else if (ctl.free_wr)
        begin
            tbl_we    = 1'b1;
            tbl_wdata = tbl_rdata & KEEP_MASK;
        end
    end

    // Link write port: list build sweep or page push.
    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = LINK_W'(ent_page);
        link_wdata = head_reg;
        if (ctl.link_step)
        begin
            link_we    = 32'(sweep_reg) < PHYS_PAGES;
            link_waddr = LINK_W'(sweep_reg);
            link_wdata = ((32'(sweep_reg) + 1) < PHYS_PAGES) ? LINK_W'(32'(sweep_reg) + 1) : '0;
        end
        else if (ctl.free_wr)
        begin
            link_we = push_ok;
        end
    end

    pra_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (IDX_W'(ptr_reg)),
        .rdata (tbl_rdata)
    );

    pra_ram #(.WIDTH(LINK_W), .DEPTH(PHYS_PAGES)) u_link (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (head_reg),
        .rdata (link_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg  <= RSV_W'(RSV_RST);
            head_reg      <= LINK_W'(RSV_RST);
            count_reg     <= CNT_W'(PHYS_PAGES - RSV_RST);
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                reserved_reg <= cfg.reserved_pages;
            end
            if (ctl.rebuild_init)
            begin
                sweep_reg <= '0;
                if (32'(reserved_reg) < PHYS_PAGES)
                begin
                    head_reg  <= LINK_W'(reserved_reg);
                    count_reg <= CNT_W'(PHYS_PAGES - 32'(reserved_reg));
                end
                else
                begin
                    head_reg  <= '0;
                    count_reg <= '0;
                end
            end
            else if (ctl.link_step)
            begin
                sweep_reg <= SW_W'(sweep_reg + SW_W'(1));
            end
            // pop from head on fill, push to head on free
            if (ctl.fill_wr)
            begin
                head_reg  <= link_rdata;
                count_reg <= CNT_W'(count_reg - CNT_W'(1));
            end
            else if (ctl.free_wr && push_ok)
            begin
                head_reg  <= LINK_W'(ent_page);
                count_reg <= CNT_W'(count_reg + CNT_W'(1));
            end
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accepted)
        begin
            cmd_reg    <= cmd_t'(req.cmd);
            np_reg     <= np_in;
            acr_reg    <= req.access_right;
            vidx_reg   <= req.virtual_address[VA_W-1:PAGE_SHIFT];
            ptr_reg    <= (cmd_t'(req.cmd) == CMD_ALLOC) ? '0
                          : PTR_W'(req.virtual_address[VA_W-1:PAGE_SHIFT]);
            run_reg    <= '0;
            k_reg      <= '0;
            status_reg <= RS_OK;
            base_reg   <= '0;
            word_reg   <= '0;
        end
        if (ctl.set_status)
        begin
            status_reg <= ctl.status;
        end
        if (ctl.scan_chk)
        begin
            run_reg <= marked ? '0 : PTR_W'(run_reg + PTR_W'(1));
            if (sts.scan_hit)
            begin
                ptr_reg  <= run_start;
                k_reg    <= '0;
                base_reg <= VA_W'(32'(run_start) << PAGE_SHIFT);
            end
            else
            begin
                ptr_reg <= PTR_W'(ptr_reg + PTR_W'(1));
            end
        end
        if (ctl.fill_wr || ctl.free_wr)
        begin
            ptr_reg <= PTR_W'(ptr_reg + PTR_W'(1));
            k_reg   <= PTR_W'(k_reg + PTR_W'(1));
        end
        if (ctl.read_cap)
        begin
            word_reg <= tbl_rdata;
        end
        if (ctl.load_out)
        begin
            out_status_reg <= status_reg;
            out_base_reg   <= base_reg;
            out_avail_reg  <= AVAIL_W'(count_reg);
            out_word_reg   <= word_reg;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.base_address    = out_base_reg;
    assign rsp.pages_available = out_avail_reg;
    assign rsp.entry_word      = out_word_reg;
endmodule

FILE: design/page_run_allocator.sv
// Page run allocator: at reset a clearing pass over max(PHYS_PAGES, TABLE_ENTRIES) addresses
// builds the link memory and zeroes the page table; no request is taken meanwhile.
// Allocate scans the table entry by entry, then fills the run page by page (one table
// RAM port read per entry, one link RAM read per pop). Free walks the run entry by entry.
// Read captures one table entry. Rebuild relinks the whole link memory.
// One request at a time; the result register lets the next request enter before it drains.
module page_run_allocator #(
    parameter int PHYS_PAGES    = 8192,
    parameter int TABLE_ENTRIES = 1024,
    parameter int PAGE_SHIFT    = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    pra_req_if.sink   req,
    pra_rsp_if.source rsp,
    pra_cfg_if.sink   cfg
);
    import pra_pkg::*;

    ctl_t ctl;
    sts_t sts;

    pra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    pra_dp #(
        .PHYS_PAGES    (PHYS_PAGES),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PAGE_SHIFT    (PAGE_SHIFT)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .ctl   (ctl),
        .sts   (sts)
    );
endmodule

FILE: design/pra_checker.sv
// Port-level checks for page_run_allocator, attached by bind.
// Depends on pra_pkg for field widths.
module pra_checker #(
    parameter int PHYS_PAGES = 8192
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [pra_pkg::STAT_W-1:0]   rsp_status,
    input logic [pra_pkg::VA_W-1:0]     rsp_base,
    input logic [pra_pkg::AVAIL_W-1:0]  rsp_avail,
    input logic [pra_pkg::ENTRY_W-1:0]  rsp_word
);
    import pra_pkg::*;

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_base)
        && $stable(rsp_avail) && $stable(rsp_word))
        else $error("response changed while stalled");

    a_err_no_base: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != RS_OK |-> rsp_base == '0 && rsp_word == '0)
        else $error("failed request carries data");

    a_base_or_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_base == '0 || rsp_word == '0)
        else $error("base and entry both set");

    a_avail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp_avail) <= PHYS_PAGES)
        else $error("free count beyond memory");
endmodule

bind page_run_allocator pra_checker #(.PHYS_PAGES(PHYS_PAGES)) u_pra_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_base   (rsp.base_address),
    .rsp_avail  (rsp.pages_available),
    .rsp_word   (rsp.entry_word)
);

FILE: test/tb_page_run_allocator.sv
// Testbench for page_run_allocator: directed and random allocate, free, read and rebuild
// requests checked against an in-bench model of the free list and page table.
// Depends on pra_pkg, pra_if and the page_run_allocator RTL.
module tb_page_run_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import pra_pkg::*;

    localparam int NPHYS  = 8192;
    localparam int NTAB   = 1024;
    localparam int PSHIFT = 16;
    localparam longint CYCLE_LIMIT = 64'd12_000_000;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VA_W-1:0]    base_address;
        logic [AVAIL_W-1:0] pages_available;
        logic [ENTRY_W-1:0] entry_word;
    } result_t;

    logic clk;
    logic rst_n;
    pra_req_if req();
    pra_rsp_if rsp();
    pra_cfg_if cfg();

    page_run_allocator dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg));

    // allocator model state
    int unsigned     m_reserved;
    int unsigned     m_link [NPHYS];
    int unsigned     m_head;
    int unsigned     m_count;
    logic [ENTRY_W-1:0] m_table [NTAB];

    result_t expected_results [$];
    int  errors;
    longint cycles;
    bit  send_idle_on;
    bit  recv_idle_on;
    bit  hold_rsp;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_page_run_allocator: errors");
            $finish;
        end
    end

    function automatic void model_rebuild();
        for (int n = 0; n < NPHYS; n++)
            m_link[n] = (n + 1 < NPHYS) ? n + 1 : 0;
        if (m_reserved < NPHYS) begin
            m_head  = m_reserved;
            m_count = NPHYS - m_reserved;
        end else begin
            m_head  = 0;
            m_count = 0;
        end
    endfunction

    function automatic int unsigned model_pop();
        int unsigned pg;
        pg = m_head;
        if (m_count == 0)
            return 0;
        m_head = (pg < NPHYS) ? m_link[pg] : 0;
        m_count--;
        return pg & 16'hFFFF;
    endfunction

    function automatic void model_push(int unsigned pg);
        if (pg < m_reserved || pg >= NPHYS || m_count >= NPHYS)
            return;
        m_link[pg] = m_head & 16'hFFFF;
        m_head = pg;
        m_count++;
    endfunction

    function automatic result_t predict_request(cmd_t c, logic [AMT_W-1:0] amt,
                                                logic [ACR_W-1:0] acr,
                                                logic [VA_W-1:0] va);
        result_t r;
        int unsigned idx, np, start, k;
        bit found;
        logic [ENTRY_W-1:0] e;
        r = '0;
        r.status = RS_OK;
        idx = va >> PSHIFT;
        case (c)
            CMD_ALLOC: begin
                np = (amt + 27'h000FFFF) >> PSHIFT;
                if (acr == 0 || np == 0)
                    r.status = RS_BAD;
                else if (np > m_count)
                    r.status = RS_SHORT;
                else if (np > NTAB)
                    r.status = RS_NORUN;
                else begin
                    found = 1'b0;
                    for (start = 0; start + np <= NTAB && !found; start++) begin
                        for (k = 0; k < np; k++)
                            if (m_table[start + k][LAST_BIT:MID_BIT] != 0)
                                break;
                        if (k == np)
                            found = 1'b1;
                    end
                    if (!found)
                        r.status = RS_NORUN;
                    else begin
                        start--;
                        for (k = 0; k < np; k++) begin
                            e = '0;
                            e[(k + 1 == np) ? LAST_BIT : MID_BIT] = 1'b1;
                            e[18:16] = acr;
                            e[15:0] = model_pop();
                            m_table[start + k] = e;
                        end
                        r.base_address = start << PSHIFT;
                    end
                end
            end
            CMD_FREE: begin
                if (idx >= NTAB)
                    r.status = RS_BAD;
                else if (m_table[idx][LAST_BIT:MID_BIT] == 0)
                    r.status = RS_NOTALLOC;
                else
                    for (int n = idx; n < NTAB; n++) begin
                        e = m_table[n];
                        if (e[LAST_BIT:MID_BIT] == 0)
                            break;
                        model_push(e[15:0]);
                        m_table[n] = e & KEEP_MASK;
                        if (e[LAST_BIT])
                            break;
                    end
            end
            CMD_READ: begin
                if (idx >= NTAB)
                    r.status = RS_BAD;
                else
                    r.entry_word = m_table[idx];
            end
            default: model_rebuild();
        endcase
        r.pages_available = m_count[AVAIL_W-1:0];
        return r;
    endfunction

    task automatic random_gap(bit on);
        if (on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 16)) @(negedge clk);
    endtask

    // send one request; predict at the accepting edge
    task automatic send_request(cmd_t c, logic [AMT_W-1:0] amt, logic [ACR_W-1:0] acr,
                                logic [VA_W-1:0] va);
        random_gap(send_idle_on);
        req.valid = 1'b1;
        req.cmd = c;
        req.byte_amount = amt;
        req.access_right = acr;
        req.virtual_address = va;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        expected_results.push_back(predict_request(c, amt, acr, va));
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // every request gives a result, so the block is idle once drained
    task automatic write_reserved(logic [RSV_W-1:0] value);
        wait_drained();
        repeat (20) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.reserved_pages <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        m_reserved = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    always @(posedge clk) begin
        result_t got, want;
        if (rst_n && rsp.valid && rsp.ready) begin
            got = {rsp.status, rsp.base_address, rsp.pages_available, rsp.entry_word};
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: status %0d", got.status);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.status != want.status) begin
                    $error("status expected %0d got %0d", want.status, got.status);
                    errors++;
                end
                if (got.base_address != want.base_address) begin
                    $error("base_address expected %h got %h", want.base_address,
                           got.base_address);
                    errors++;
                end
                if (got.pages_available != want.pages_available) begin
                    $error("pages_available expected %0d got %0d", want.pages_available,
                           got.pages_available);
                    errors++;
                end
                if (got.entry_word != want.entry_word) begin
                    $error("entry_word expected %h got %h", want.entry_word,
                           got.entry_word);
                    errors++;
                end
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial begin
        rsp.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_rsp) begin
                rsp.ready <= 1'b0;
                repeat (3000) @(negedge clk);
                hold_rsp = 1'b0;
            end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end else
                rsp.ready <= 1'b1;
        end
    end

    function automatic logic [AMT_W-1:0] pages_to_bytes(int unsigned np);
        return (np << PSHIFT) - $urandom_range(0, 65535);
    endfunction

    task automatic test_directed();
        send_request(CMD_READ, 0, 0, 0);
        send_request(CMD_ALLOC, 0, 3, 0);                          // zero amount
        send_request(CMD_ALLOC, 65536, 0, 0);                      // bad rights
        send_request(CMD_ALLOC, 27'h4000000, 7, 0);                // 1024 pages, the whole table
        send_request(CMD_ALLOC, 27'h7FFFFFF, 1, 0);                // longer than the table
        send_request(CMD_ALLOC, 1, 7, 26'h3FFFFFF);
        send_request(CMD_ALLOC, 65537, 5, 0);
        send_request(CMD_READ, 0, 0, 26'h10000);
        send_request(CMD_READ, 0, 0, 26'h20000);
        send_request(CMD_READ, 0, 0, 26'h3FFFFFF);                 // last table entry
        send_request(CMD_FREE, 0, 0, 26'h3FFFFFF);
        send_request(CMD_FREE, 0, 0, 26'h0400000 - 26'h10000);     // free from inside the run
        send_request(CMD_FREE, 0, 0, 26'h10000);                   // walk of a run
        send_request(CMD_ALLOC, 27'h4000000, 2, 0);                // longer than free space
        send_request(CMD_FREE, 0, 0, 0);
        send_request(CMD_ALLOC, 27'h3FF0000, 4, 0);                // 1023 pages
        send_request(CMD_ALLOC, 27'h20000, 4, 0);                  // no run fits
        send_request(CMD_ALLOC, 27'h10000, 6, 0);                  // last free entry
        send_request(CMD_READ, 0, 0, 26'h3FF0000);
        send_request(CMD_FREE, 0, 0, 26'h3FF0000);
        send_request(CMD_FREE, 0, 0, 26'h0010000);                 // free from the middle
        send_request(CMD_FREE, 0, 0, 0);
        send_request(CMD_REBUILD, 0, 0, 0);
    endtask

    // raise reserved so pages below it are handed out, then dropped on free
    task automatic test_reserved_extremes();
        write_reserved(13'd1);
        send_request(CMD_REBUILD, 0, 0, 0);
        send_request(CMD_ALLOC, 27'h30000, 1, 0);
        write_reserved(13'd300);
        send_request(CMD_ALLOC, 27'h20000, 2, 0);
        send_request(CMD_FREE, 0, 0, 0);
        send_request(CMD_FREE, 0, 0, 26'h30000);
        write_reserved(13'd8191);
        send_request(CMD_REBUILD, 0, 0, 0);
        send_request(CMD_ALLOC, 65536, 3, 0);
        send_request(CMD_ALLOC, 65536, 3, 0);                      // too few pages
        send_request(CMD_FREE, 0, 0, 26'h40000);
        write_reserved(13'h1FFF);
        send_request(CMD_REBUILD, 0, 0, 0);                        // reserved at its largest value
        send_request(CMD_ALLOC, 65536, 3, 0);
        write_reserved(13'd16);
        send_request(CMD_REBUILD, 0, 0, 0);
    endtask

    task automatic random_request();
        int unsigned pick, np, i;
        logic [VA_W-1:0] va;
        pick = $urandom_range(0, 99);
        va = $urandom_range(0, 1023) << PSHIFT;
        if ($urandom_range(0, 3) == 0)
            va = va | $urandom_range(0, 65535);
        if (pick < 45) begin
            np = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 1100)
                                               : $urandom_range(1, 40);
            send_request(CMD_ALLOC, ($urandom_range(0, 30) == 0) ? $urandom()
                         : pages_to_bytes(np), ($urandom_range(0, 15) == 0) ? 0
                         : $urandom_range(1, 7), $urandom());
        end else if (pick < 80) begin
            // the check for a nearby marked entry leaves va unchanged
            i = va >> PSHIFT;
            if (i > 0 && m_table[i - 1][LAST_BIT] && m_table[i][LAST_BIT:MID_BIT] != 0
                && $urandom_range(0, 1))
                va = va;
            send_request(CMD_FREE, $urandom(), $urandom(),
                         ($urandom_range(0, 15) == 0) ? $urandom() : va);
        end else if (pick < 97)
            send_request(CMD_READ, $urandom(), $urandom(),
                         ($urandom_range(0, 15) == 0) ? $urandom() : va);
        else
            send_request(CMD_REBUILD, $urandom(), $urandom(), $urandom());
    endtask

    task automatic test_random(int n);
        repeat (n) random_request();
    endtask

    // hold the response side so the block backs up the request channel
    task automatic test_backpressure();
        wait_drained();
        hold_rsp = 1'b1;
        repeat (6) send_request(CMD_READ, 0, 0, $urandom_range(0, 1023) << PSHIFT);
        wait_drained();
    endtask

    initial begin
        rst_n = 1'b0;
        errors = 0;
        cycles = 0;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        hold_rsp = 1'b0;
        req.valid = 1'b0;
        req.cmd = CMD_ALLOC;
        req.byte_amount = '0;
        req.access_right = '0;
        req.virtual_address = '0;
        cfg.valid = 1'b0;
        cfg.reserved_pages = '0;
        m_reserved = 16;
        for (int n = 0; n < NTAB; n++)
            m_table[n] = '0;
        model_rebuild();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_reserved_extremes();
        test_random(120);
        test_backpressure();
        write_reserved(13'd4096);
        test_random(60);
        write_reserved(13'd16);
        send_request(CMD_REBUILD, 0, 0, 0);
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        test_random(70);

        wait_drained();
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("tb_page_run_allocator: clean");
        else
            $display("tb_page_run_allocator: errors");
        $finish;
    end
endmodule
